>>> rtl/kpd_pkg.sv
// Package for the keypad debounce and long-press event unit.
// Holds sequencer states, button indices, event codes and register defaults.
// No dependencies.
package kpd_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 16;
    localparam int unsigned NUM_BUTTONS     = 9;
    localparam int unsigned CFG_W           = 16;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST  = 16'd50;
    localparam logic [CFG_W-1:0] AUTO_LONG_RST = 16'd3000;
    localparam logic [CFG_W-1:0] BL_LONG_RST   = 16'd5000;
    localparam logic [CFG_W-1:0] COMBO_RST     = 16'd5000;

    localparam logic [1:0] CFG_DEBOUNCE  = 2'd0;
    localparam logic [1:0] CFG_AUTO_LONG = 2'd1;
    localparam logic [1:0] CFG_BL_LONG   = 2'd2;
    localparam logic [1:0] CFG_COMBO     = 2'd3;

    localparam logic [3:0] KEY_MODE      = 4'd4;
    localparam logic [3:0] KEY_AUTO      = 4'd6;
    localparam logic [3:0] KEY_BACKLIGHT = 4'd8;
    localparam logic [3:0] BTN_LAST      = 4'd8;

    localparam logic [3:0] EV_NONE      = 4'd0;
    localparam logic [3:0] EV_PORT1     = 4'd1;
    localparam logic [3:0] EV_STBD1     = 4'd2;
    localparam logic [3:0] EV_PORT10    = 4'd3;
    localparam logic [3:0] EV_STBD10    = 4'd4;
    localparam logic [3:0] EV_MODE      = 4'd5;
    localparam logic [3:0] EV_INFO      = 4'd6;
    localparam logic [3:0] EV_AUTO      = 4'd7;
    localparam logic [3:0] EV_AUTO_LONG = 4'd8;
    localparam logic [3:0] EV_STANDBY   = 4'd9;
    localparam logic [3:0] EV_BL        = 4'd10;
    localparam logic [3:0] EV_BL_LONG   = 4'd11;
    localparam logic [3:0] EV_COMBO     = 4'd12;

    localparam logic OP_POLL = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEB,
        S_LONG,
        S_ARM,
        S_CHK,
        S_POP,
        S_DONE
    } t_state;

    function automatic logic [3:0] press_code(input logic [3:0] idx);
        logic [3:0] c;
        unique case (idx)
            4'd0:    c = EV_PORT1;
            4'd1:    c = EV_STBD1;
            4'd2:    c = EV_PORT10;
            4'd3:    c = EV_STBD10;
            4'd4:    c = EV_MODE;
            4'd5:    c = EV_INFO;
            4'd6:    c = EV_AUTO;
            4'd7:    c = EV_STANDBY;
            4'd8:    c = EV_BL;
            default: c = EV_NONE;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/keypad_debounce_long_press_events_unit.sv
// Keypad debounce, long-press, overlap and combo detection with an event FIFO.
// Uses kpd_pkg; one shared 32-bit subtract and compare unit under a sequencer.
// Poll item from accept to result register: nine button steps, two hold checks, two
// combo steps, one output step; pop item: S_POP, then S_DONE.
// One item at a time: the next waits until the last result is loaded into the output.
// Synchronous active-low reset: levels released, timers and flags zero, FIFO empty.
module keypad_debounce_long_press_events_unit #(
    parameter int unsigned QUEUE_DEPTH = kpd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_index,
    input  logic [kpd_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_op,
    input  logic [31:0]               i_now_ms,
    input  logic [8:0]                i_levels,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_event_valid,
    output logic [3:0]                o_event_code,
    output logic [3:0]                o_queue_count
);
    import kpd_pkg::*;

    localparam int unsigned AW    = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = (AW + 1 >= 5) ? AW + 1 : 5;
    localparam logic [AW-1:0]    LAST_PTR  = AW'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(15);

    t_state r_state, n_state;

    logic [CFG_W-1:0] r_debounce, r_auto_long, r_bl_long, r_combo_long;

    logic        r_op;
    logic [31:0] r_now;
    logic [8:0]  r_levels;
    logic [3:0]  r_idx, n_idx;

    logic [8:0]  r_acc, n_acc;
    logic [31:0] r_ct [NUM_BUTTONS];
    logic        n_ct_we;
    logic [31:0] r_ps_mode, n_ps_mode, r_ps_auto, n_ps_auto, r_ps_bl, n_ps_bl;
    logic [2:0]  r_held, n_held;
    logic [1:0]  r_long, n_long;
    logic        r_overlap, n_overlap, r_armed, n_armed, r_sent, n_sent;
    logic [31:0] r_combo_start, n_combo_start;

    logic [3:0]  r_mem [QUEUE_DEPTH];
    logic [3:0]  r_rd_data;
    logic        r_pop_hit, n_pop_hit;
    logic [AW-1:0] r_head, r_tail, n_tail;
    logic [AW-1:0] w_head_inc, w_tail_inc;
    logic        w_full, w_empty;
    logic        w_push;
    logic [3:0]  w_push_code;
    logic [CNT_W-1:0] w_count;

    logic        r_out_valid, r_ev_valid;
    logic [3:0]  r_ev_code, r_q_count;
    logic        w_load_out;

    // shared subtract and compare unit
    logic [31:0]      u_a, u_b;
    logic [CFG_W-1:0] u_th;
    logic [32:0]      u_diff;
    logic             u_gt, u_ge, u_borrow;

    logic w_cur;

    assign u_diff   = {1'b0, u_a} - {1'b0, u_b};
    assign u_borrow = u_diff[32];
    assign u_gt     = u_diff[31:0] >  {16'd0, u_th};
    assign u_ge     = u_diff[31:0] >= {16'd0, u_th};

    assign w_head_inc = (r_head == LAST_PTR) ? '0 : r_head + 1'b1;
    assign w_tail_inc = (r_tail == LAST_PTR) ? '0 : r_tail + 1'b1;
    assign w_full     = (w_head_inc == r_tail);
    assign w_empty    = (r_head == r_tail);
    assign w_count    = (r_head >= r_tail)
                      ? CNT_W'(r_head) - CNT_W'(r_tail)
                      : CNT_W'(r_head) + DEPTH_CNT - CNT_W'(r_tail);

    assign w_cur      = r_levels[r_idx];
    assign o_in_ready = (r_state == S_IDLE);
    assign w_load_out = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        unique case (r_state)
            S_DEB: begin
                u_a = r_now; u_b = r_ct[r_idx]; u_th = r_debounce;
            end
            S_LONG: begin
                u_a  = r_now;
                u_b  = (r_idx == KEY_AUTO) ? r_ps_auto : r_ps_bl;
                u_th = (r_idx == KEY_AUTO) ? r_auto_long : r_bl_long;
            end
            S_ARM: begin
                u_a = r_ps_bl; u_b = r_ps_mode; u_th = '0;
            end
            S_CHK: begin
                u_a = r_now; u_b = r_combo_start; u_th = r_combo_long;
            end
            default: begin
                u_a = r_now; u_b = '0; u_th = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (i_in_valid) n_state = (i_op == OP_POP) ? S_POP : S_DEB;
            end
            S_DEB: begin
                if (r_idx == KEY_AUTO || r_idx == KEY_BACKLIGHT) n_state = S_LONG;
                else n_idx = r_idx + 1'b1;
            end
            S_LONG: begin
                if (r_idx == BTN_LAST) n_state = S_ARM;
                else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_DEB;
                end
            end
            S_ARM:  n_state = S_CHK;
            S_CHK:  n_state = S_DONE;
            S_POP:  n_state = S_DONE;
            S_DONE: if (w_load_out) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_acc         = r_acc;
        n_ct_we       = 1'b0;
        n_ps_mode     = r_ps_mode;
        n_ps_auto     = r_ps_auto;
        n_ps_bl       = r_ps_bl;
        n_held        = r_held;
        n_long        = r_long;
        n_overlap     = r_overlap;
        n_armed       = r_armed;
        n_sent        = r_sent;
        n_combo_start = r_combo_start;
        n_tail        = r_tail;
        n_pop_hit     = r_pop_hit;
        w_push        = 1'b0;
        w_push_code   = EV_NONE;
        unique case (r_state)
            S_DEB: begin
                if (w_cur != r_acc[r_idx] && u_gt) begin
                    n_acc[r_idx] = w_cur;
                    n_ct_we      = 1'b1;
                    if (!w_cur) begin
                        priority if (r_idx == KEY_AUTO) begin
                            n_held[1] = 1'b1; n_ps_auto = r_now; n_long[0] = 1'b0;
                        end else if (r_idx == KEY_BACKLIGHT) begin
                            n_held[2] = 1'b1; n_ps_bl = r_now; n_long[1] = 1'b0;
                        end else if (r_idx == KEY_MODE) begin
                            n_held[0] = 1'b1; n_ps_mode = r_now;
                        end else begin
                            w_push = 1'b1; w_push_code = press_code(r_idx);
                        end
                    end else begin
                        if (r_idx == KEY_AUTO && r_held[1]) begin
                            n_held[1] = 1'b0;
                            w_push = !r_long[0]; w_push_code = EV_AUTO;
                        end
                        if (r_idx == KEY_BACKLIGHT && r_held[2]) begin
                            n_held[2] = 1'b0;
                            w_push = !r_overlap && !r_long[1]; w_push_code = EV_BL;
                        end
                        if (r_idx == KEY_MODE && r_held[0]) begin
                            n_held[0] = 1'b0;
                            w_push = !r_overlap; w_push_code = EV_MODE;
                        end
                    end
                end
            end
            S_LONG: begin
                if (r_idx == KEY_AUTO) begin
                    if (r_held[1] && !r_long[0] && u_ge) begin
                        n_long[0] = 1'b1; w_push = 1'b1; w_push_code = EV_AUTO_LONG;
                    end
                end else if (r_held[2] && !r_long[1] && !r_overlap && u_ge) begin
                    n_long[1] = 1'b1; w_push = 1'b1; w_push_code = EV_BL_LONG;
                end
            end
            S_ARM: begin
                if (r_held[0] && r_held[2]) begin
                    n_overlap = 1'b1;
                    if (!r_armed) begin
                        n_armed       = 1'b1;
                        n_sent        = 1'b0;
                        n_combo_start = u_borrow ? r_ps_mode : r_ps_bl;
                    end
                end else begin
                    n_armed       = 1'b0;
                    n_sent        = 1'b0;
                    n_combo_start = '0;
                    if (!r_held[0] && !r_held[2]) n_overlap = 1'b0;
                end
            end
            S_CHK: begin
                if (r_held[0] && r_held[2] && !r_sent && u_ge) begin
                    n_sent = 1'b1; w_push = 1'b1; w_push_code = EV_COMBO;
                end
            end
            S_POP: begin
                n_pop_hit = !w_empty;
                if (!w_empty) n_tail = w_tail_inc;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce   <= DEBOUNCE_RST;
            r_auto_long  <= AUTO_LONG_RST;
            r_bl_long    <= BL_LONG_RST;
            r_combo_long <= COMBO_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DEBOUNCE:  r_debounce   <= i_cfg_data;
                CFG_AUTO_LONG: r_auto_long  <= i_cfg_data;
                CFG_BL_LONG:   r_bl_long    <= i_cfg_data;
                CFG_COMBO:     r_combo_long <= i_cfg_data;
                default:       r_debounce   <= r_debounce;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_idx         <= '0;
            r_acc         <= '1;
            r_ps_mode     <= '0;
            r_ps_auto     <= '0;
            r_ps_bl       <= '0;
            r_held        <= '0;
            r_long        <= '0;
            r_overlap     <= 1'b0;
            r_armed       <= 1'b0;
            r_sent        <= 1'b0;
            r_combo_start <= '0;
            r_head        <= '0;
            r_tail        <= '0;
            r_pop_hit     <= 1'b0;
            r_out_valid   <= 1'b0;
            for (int k = 0; k < NUM_BUTTONS; k++) r_ct[k] <= '0;
        end else begin
            r_state       <= n_state;
            r_idx         <= n_idx;
            r_acc         <= n_acc;
            r_ps_mode     <= n_ps_mode;
            r_ps_auto     <= n_ps_auto;
            r_ps_bl       <= n_ps_bl;
            r_held        <= n_held;
            r_long        <= n_long;
            r_overlap     <= n_overlap;
            r_armed       <= n_armed;
            r_sent        <= n_sent;
            r_combo_start <= n_combo_start;
            r_tail        <= n_tail;
            r_pop_hit     <= n_pop_hit;
            if (w_push && !w_full) r_head <= w_head_inc;
            if (n_ct_we) r_ct[r_idx] <= r_now;
            if (w_load_out) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    // item latch, FIFO store and result payload
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_op     <= i_op;
            r_now    <= i_now_ms;
            r_levels <= i_levels;
        end
        if (w_push && !w_full) r_mem[r_head] <= w_push_code;
        if (r_state == S_POP) r_rd_data <= r_mem[r_tail];
        if (w_load_out) begin
            r_ev_valid <= (r_op == OP_POP) && r_pop_hit;
            r_ev_code  <= ((r_op == OP_POP) && r_pop_hit) ? r_rd_data : EV_NONE;
            r_q_count  <= (w_count > CNT_MAX) ? 4'd15 : w_count[3:0];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_event_valid = r_ev_valid;
    assign o_event_code  = r_ev_code;
    assign o_queue_count = r_q_count;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("accepted a second item without finishing the first");

    a_full_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && w_full) |=> $stable(r_head))
        else $error("full queue advanced its write pointer");

    a_no_code_without_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_event_valid) |-> (o_event_code == EV_NONE))
        else $error("event code shown without an event");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEB || r_state == S_LONG) |-> (r_idx <= BTN_LAST))
        else $error("button step out of range");

endmodule

>>> dv/testbench.sv
// Testbench for keypad_debounce_long_press_events_unit: directed table, then random
// poll/pop traffic under several register settings and handshake idling patterns.
// Depends on kpd_pkg and the unit; checked against a keypad model or typed table rows.
module testbench;
    import kpd_pkg::*;

    localparam int unsigned QD          = QUEUE_DEPTH_DEF;
    localparam int          DIR_N       = 25;
    localparam int          PHASES      = 7;
    localparam int          PHASE_ITEMS = 240;
    localparam int          HOLD_LEN    = 400;
    localparam logic        TYPED       = 1'b1;
    localparam logic        MODELLED    = 1'b0;

    typedef struct packed {
        logic       ev_valid;
        logic [3:0] code;
        logic [3:0] count;
    } t_report;

    typedef struct packed {
        logic        op;
        logic [31:0] now;
        logic [8:0]  lv;
        logic        typed;
        t_report     want;
    } t_dir_row;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic [1:0]        i_cfg_index = CFG_DEBOUNCE;
    logic [CFG_W-1:0]  i_cfg_data  = '0;
    logic              i_in_valid  = 1'b0;
    logic              i_op        = OP_POLL;
    logic [31:0]       i_now_ms    = '0;
    logic [8:0]        i_levels    = '1;
    logic              i_out_ready = 1'b0;
    logic              o_in_ready;
    logic              o_out_valid;
    logic              o_event_valid;
    logic [3:0]        o_event_code;
    logic [3:0]        o_queue_count;

    always #5 i_clk = ~i_clk;

    keypad_debounce_long_press_events_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_op          (i_op),
        .i_now_ms      (i_now_ms),
        .i_levels      (i_levels),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_event_valid (o_event_valid),
        .o_event_code  (o_event_code),
        .o_queue_count (o_queue_count)
    );

    // keypad state as the unit should hold it
    logic [15:0] deb_ms, auto_ms, bl_ms, combo_ms;
    logic [8:0]  kp_lvl;
    logic [31:0] kp_chg [NUM_BUTTONS];
    logic [3:0]  press_ev [NUM_BUTTONS];
    logic [31:0] mode_t0, auto_t0, bl_t0, combo_t0;
    logic        mode_held, auto_held, bl_held;
    logic        auto_long_sent, bl_long_sent;
    logic        overlap, combo_armed, combo_sent;
    logic [3:0]  ev_store [QD];
    int unsigned ev_head, ev_tail;

    t_report     due_reports [$];
    t_report     seen_want;
    t_dir_row    dir_tab [DIR_N];
    int          mismatch_n   = 0;
    int          tx_idle_pct  = 0;
    int          rx_stall_pct = 0;
    int          hold_asked   = 0;
    int          hold_served  = 0;
    int          hold_left    = 0;

    task automatic keypad_reset();
        deb_ms         = DEBOUNCE_RST;
        auto_ms        = AUTO_LONG_RST;
        bl_ms          = BL_LONG_RST;
        combo_ms       = COMBO_RST;
        kp_lvl         = '1;
        mode_t0        = '0;
        auto_t0        = '0;
        bl_t0          = '0;
        combo_t0       = '0;
        mode_held      = 1'b0;
        auto_held      = 1'b0;
        bl_held        = 1'b0;
        auto_long_sent = 1'b0;
        bl_long_sent   = 1'b0;
        overlap        = 1'b0;
        combo_armed    = 1'b0;
        combo_sent     = 1'b0;
        ev_head        = 0;
        ev_tail        = 0;
        for (int b = 0; b < NUM_BUTTONS; b++) kp_chg[b] = '0;
        for (int b = 0; b < int'(QD); b++) ev_store[b] = EV_NONE;
        press_ev[0] = EV_PORT1;
        press_ev[1] = EV_STBD1;
        press_ev[2] = EV_PORT10;
        press_ev[3] = EV_STBD10;
        press_ev[4] = EV_MODE;
        press_ev[5] = EV_INFO;
        press_ev[6] = EV_AUTO;
        press_ev[7] = EV_STANDBY;
        press_ev[8] = EV_BL;
    endtask

    task automatic push_event(input logic [3:0] c);
        int unsigned nxt;
        nxt = (ev_head + 1) % QD;
        if (nxt != ev_tail) begin
            ev_store[ev_head] = c;
            ev_head = nxt;
        end
    endtask

    task automatic keypad_step(input logic op, input logic [31:0] now, input logic [8:0] lv,
                               output t_report r);
        logic [31:0] dt;
        int unsigned n;
        int          b;
        r = '0;
        if (op == OP_POLL) begin
            for (b = 0; b < NUM_BUTTONS; b++) begin
                dt = now - kp_chg[b];
                if (lv[b] != kp_lvl[b] && dt > 32'(deb_ms)) begin
                    kp_lvl[b] = lv[b];
                    kp_chg[b] = now;
                    if (!lv[b]) begin
                        if (b == KEY_AUTO) begin
                            auto_held = 1'b1;
                            auto_t0 = now;
                            auto_long_sent = 1'b0;
                        end else if (b == KEY_BACKLIGHT) begin
                            bl_held = 1'b1;
                            bl_t0 = now;
                            bl_long_sent = 1'b0;
                        end else if (b == KEY_MODE) begin
                            mode_held = 1'b1;
                            mode_t0 = now;
                        end else begin
                            push_event(press_ev[b]);
                        end
                    end else begin
                        if (b == KEY_AUTO && auto_held) begin
                            auto_held = 1'b0;
                            if (!auto_long_sent) push_event(EV_AUTO);
                        end
                        if (b == KEY_BACKLIGHT && bl_held) begin
                            bl_held = 1'b0;
                            if (!overlap && !bl_long_sent) push_event(EV_BL);
                        end
                        if (b == KEY_MODE && mode_held) begin
                            mode_held = 1'b0;
                            if (!overlap) push_event(EV_MODE);
                        end
                    end
                end
                if (b == KEY_AUTO && auto_held && !auto_long_sent
                    && (now - auto_t0) >= 32'(auto_ms)) begin
                    auto_long_sent = 1'b1;
                    push_event(EV_AUTO_LONG);
                end
                if (b == KEY_BACKLIGHT && bl_held && !bl_long_sent && !overlap
                    && (now - bl_t0) >= 32'(bl_ms)) begin
                    bl_long_sent = 1'b1;
                    push_event(EV_BL_LONG);
                end
            end
            if (mode_held && bl_held) begin
                overlap = 1'b1;
                if (!combo_armed) begin
                    combo_armed = 1'b1;
                    combo_sent = 1'b0;
                    combo_t0 = (mode_t0 > bl_t0) ? mode_t0 : bl_t0;
                end
                if (!combo_sent && (now - combo_t0) >= 32'(combo_ms)) begin
                    combo_sent = 1'b1;
                    push_event(EV_COMBO);
                end
            end else begin
                combo_armed = 1'b0;
                combo_sent = 1'b0;
                combo_t0 = '0;
                if (!mode_held && !bl_held) overlap = 1'b0;
            end
        end else if (ev_head != ev_tail) begin
            r.ev_valid = 1'b1;
            r.code = ev_store[ev_tail];
            ev_tail = (ev_tail + 1) % QD;
        end
        n = (ev_head + QD - ev_tail) % QD;
        r.count = (n > 15) ? 4'd15 : n[3:0];
    endtask

    // returns at the edge where the item is taken
    task automatic offer_item(input logic op, input logic [31:0] now, input logic [8:0] lv,
                              input logic typed, input t_report want);
        t_report got;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_now_ms   <= now;
        i_levels   <= lv;
        do @(posedge i_clk); while (!o_in_ready);
        keypad_step(op, now, lv, got);
        due_reports.push_back(typed ? want : got);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (due_reports.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready) begin
            if (due_reports.size() == 0) begin
                mismatch_n++;
                if (mismatch_n <= 10)
                    $display("unexpected item: v=%0d code=%0d count=%0d",
                             o_event_valid, o_event_code, o_queue_count);
            end else begin
                seen_want = due_reports.pop_front();
                if (o_event_valid !== seen_want.ev_valid || o_event_code !== seen_want.code
                    || o_queue_count !== seen_want.count) begin
                    mismatch_n++;
                    if (mismatch_n <= 10)
                        $display("mismatch: want v/code/count %0d/%0d/%0d, got %0d/%0d/%0d",
                                 seen_want.ev_valid, seen_want.code, seen_want.count,
                                 o_event_valid, o_event_code, o_queue_count);
                end
            end
        end
        if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (hold_served != hold_asked) begin
            hold_served <= hold_served + 1;
            hold_left   <= HOLD_LEN;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    initial begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        logic        op;
        logic [31:0] now, t_now;
        logic [8:0]  lv, t_lvl;
        logic [15:0] d, a, l, c;
        int unsigned longest, k;
        int          b;
        t_dir_row    row;

        // debounce reject, all pressed, holds, combo, overlap releases, full queue, wrap
        dir_tab[0]  = {OP_POP,  32'd0,          9'h000, TYPED,    1'b0, EV_NONE, 4'd0};
        dir_tab[1]  = {OP_POLL, 32'd0,          9'h1FF, TYPED,    1'b0, EV_NONE, 4'd0};
        dir_tab[2]  = {OP_POLL, 32'd10,         9'h000, TYPED,    1'b0, EV_NONE, 4'd0};
        dir_tab[3]  = {OP_POLL, 32'd100,        9'h000, MODELLED, 9'd0};
        for (int i = 4; i < 10; i++)
            dir_tab[i] = {OP_POP, 32'd0, 9'h1FF, MODELLED, 9'd0};
        dir_tab[10] = {OP_POLL, 32'd3100,       9'h000, MODELLED, 9'd0};
        dir_tab[11] = {OP_POLL, 32'd5100,       9'h000, MODELLED, 9'd0};
        dir_tab[12] = {OP_POLL, 32'd5200,       9'h1FF, MODELLED, 9'd0};
        dir_tab[13] = {OP_POP,  32'd0,          9'h000, MODELLED, 9'd0};
        dir_tab[14] = {OP_POP,  32'd0,          9'h000, MODELLED, 9'd0};
        dir_tab[15] = {OP_POP,  32'hFFFF_FFFF,  9'h1FF, TYPED,    1'b0, EV_NONE, 4'd0};
        dir_tab[16] = {OP_POLL, 32'd5300,       9'h150, MODELLED, 9'd0};
        dir_tab[17] = {OP_POLL, 32'd5400,       9'h1FF, MODELLED, 9'd0};
        dir_tab[18] = {OP_POLL, 32'd5500,       9'h150, MODELLED, 9'd0};
        dir_tab[19] = {OP_POLL, 32'd5600,       9'h1FF, MODELLED, 9'd0};
        dir_tab[20] = {OP_POLL, 32'd5700,       9'h150, TYPED,    1'b0, EV_NONE, 4'd15};
        dir_tab[21] = {OP_POP,  32'hFFFF_FFFF,  9'h000, MODELLED, 9'd0};
        dir_tab[22] = {OP_POLL, 32'hFFFF_FFF0,  9'h1FF, MODELLED, 9'd0};
        dir_tab[23] = {OP_POLL, 32'h0000_0040,  9'h1BF, MODELLED, 9'd0};
        dir_tab[24] = {OP_POLL, 32'h0000_0C00,  9'h1BF, MODELLED, 9'd0};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        keypad_reset();

        for (int i = 0; i < DIR_N; i++) begin
            row = dir_tab[i];
            offer_item(row.op, row.now, row.lv, row.typed, row.want);
        end
        t_now = 32'h0000_0C00;
        t_lvl = 9'h1BF;

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            case (ph)
                0:       begin d = 16'd5;     a = 16'd40;    l = 16'd60;    c = 16'd80;    end
                1:       begin d = 16'd0;     a = 16'd1;     l = 16'd1;     c = 16'd1;     end
                2:       begin d = 16'd0;     a = 16'd0;     l = 16'd0;     c = 16'd0;     end
                3:       begin d = 16'd20;    a = 16'd100;   l = 16'd150;   c = 16'd120;   end
                4:       begin d = 16'hFFFF;  a = 16'hFFFF;  l = 16'hFFFF;  c = 16'hFFFF;  end
                5:       begin d = 16'hFFFF;  a = 16'd1;     l = 16'hFFFF;  c = 16'd1;     end
                default: begin d = 16'd10;    a = 16'd300;   l = 16'd50;    c = 16'd200;   end
            endcase
            i_cfg_we    <= 1'b1;
            i_cfg_index <= CFG_DEBOUNCE;
            i_cfg_data  <= d;
            @(posedge i_clk);
            deb_ms = d;
            i_cfg_index <= CFG_AUTO_LONG;
            i_cfg_data  <= a;
            @(posedge i_clk);
            auto_ms = a;
            i_cfg_index <= CFG_BL_LONG;
            i_cfg_data  <= l;
            @(posedge i_clk);
            bl_ms = l;
            i_cfg_index <= CFG_COMBO;
            i_cfg_data  <= c;
            @(posedge i_clk);
            combo_ms = c;
            i_cfg_we <= 1'b0;

            case (ph % 4)
                0:       begin tx_idle_pct <= 0;  rx_stall_pct <= 0;  end
                1:       begin tx_idle_pct <= 62; rx_stall_pct <= 0;  end
                2:       begin tx_idle_pct <= 0;  rx_stall_pct <= 62; end
                default: begin tx_idle_pct <= 23; rx_stall_pct <= 23; end
            endcase
            if (ph == 2) hold_asked <= hold_asked + 1;
            if (ph == PHASES - 1) t_now = 32'hFFFF_0000;

            longest = (a > l) ? 32'(a) : 32'(l);
            longest = (32'(c) > longest) ? 32'(c) : longest;
            longest = (longest == 0) ? 1 : longest;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 4 && n == PHASE_ITEMS / 2) settle();
                k = $urandom_range(99);
                if (k < 35) begin
                    op  = OP_POP;
                    now = $urandom;
                    lv  = 9'($urandom_range(511));
                end else if (k < 42) begin
                    // noise: any time, any levels
                    op  = OP_POLL;
                    now = $urandom;
                    lv  = 9'($urandom_range(511));
                end else begin
                    op = OP_POLL;
                    k  = $urandom_range(9);
                    if (k < 3)      t_now = t_now + $urandom_range(d);
                    else if (k < 6) t_now = t_now + d + $urandom_range(40, 1);
                    else if (k < 9) t_now = t_now + $urandom_range(longest + 50);
                    else            t_now = t_now + $urandom_range(3 * longest + 100);
                    k = $urandom_range(9);
                    if (k < 5) begin
                        // at least half the flips land on mode, auto or backlight
                        b = $urandom_range(1) ? int'(KEY_MODE) + 2 * $urandom_range(2)
                                              : $urandom_range(8);
                        t_lvl[b] = ~t_lvl[b];
                    end else if (k == 5) begin
                        t_lvl[KEY_MODE]      = 1'b0;
                        t_lvl[KEY_BACKLIGHT] = 1'b0;
                    end else if (k == 6) begin
                        t_lvl = '1;
                    end
                    now = t_now;
                    lv  = t_lvl;
                end
                offer_item(op, now, lv, MODELLED, '0);
            end
        end

        settle();
        repeat (20) @(posedge i_clk);
        if (mismatch_n == 0 && due_reports.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
